// File: design/note_on_off_pairing_table_defines.svh
// Assertion macros shared by the note pairing table RTL.
`ifndef NOTE_ON_OFF_PAIRING_TABLE_DEFINES_SVH
`define NOTE_ON_OFF_PAIRING_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define NTPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntpt assertion failed");
// Next-cycle implication, disabled while reset is high.
`define NTPT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntpt assertion failed");
`else
`define NTPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define NTPT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/ntpt_pkg.sv
// Types and codes of the note pairing table.
package ntpt_pkg;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_MATCH  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_DUMP     = 2'd3;

   // payload of one table slot (used bit kept apart, it has a reset)
   typedef struct packed {
      logic [3:0]  channel;
      logic [7:0]  note;
      logic [30:0] start_time;
      logic [15:0] tag;
      logic [31:0] order;
   } entry_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;
      logic clear_all;
      logic load;
      logic release_slot;
   } cell_ctl_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]  status;
      logic        entry_valid;
      logic [15:0] tag;
      logic [30:0] start_time;
      logic [3:0]  channel;
      logic [7:0]  note;
      logic        last;
   } rsp_type;

endpackage

// File: design/ntpt_cell.sv
// One slot of the rotating table: holds an entry and passes it to its neighbor.
module ntpt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ntpt_pkg::cell_ctl_type ctl,
   input  ntpt_pkg::entry_type   wr_data,
   input  logic                  shift_used,
   input  ntpt_pkg::entry_type   shift_data,
   output logic                  used_out,
   output ntpt_pkg::entry_type   data_out
);

   logic                used_ff;
   logic                used_in;
   ntpt_pkg::entry_type data_ff;
   ntpt_pkg::entry_type data_in;

   // used bit: clear beats load beats release beats rotation
   always_comb begin
      used_in = used_ff;
      if (ctl.clear_all) begin
         used_in = 1'b0;
      end else if (ctl.load) begin
         used_in = 1'b1;
      end else if (ctl.release_slot) begin
         used_in = 1'b0;
      end else if (ctl.shift) begin
         used_in = shift_used;
      end
   end

   // payload
   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = wr_data;
      end else if (ctl.shift) begin
         data_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign used_out = used_ff;
   assign data_out = data_ff;

endmodule

// File: design/note_on_off_pairing_table.sv
// Note-on/note-off pairing table: top level with scan sequencer and slot ring.
//
// Insert, note-off match and dump keep busy high while the slots, which sit
// in a ring of cells, rotate once past a single compare unit at its head;
// then the finish state writes or frees the chosen slot with the ring back
// home. Clear is done from idle without raising busy. Each result is shown
// for one cycle under rsp_valid and cannot be held off, so the receiver must
// take it then. A dump gives one result per open entry in ascending slot
// order, spread over the rotation, the last one (rsp_last high) from the
// finish state; every other command gives one result.
`include "note_on_off_pairing_table_defines.svh"

module note_on_off_pairing_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [3:0]  req_channel,
   input  logic [7:0]  req_note,
   input  logic [30:0] req_start_time,
   input  logic [15:0] req_tag,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_entry_valid,
   output logic [15:0] rsp_tag_out,
   output logic [30:0] rsp_time_out,
   output logic [3:0]  rsp_channel_out,
   output logic [7:0]  rsp_note_out,
   output logic        rsp_last
);

   localparam int IW = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        step_ff, step_in;
   logic [1:0]           op_ff, op_in;
   ntpt_pkg::entry_type  req_ff, req_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        idx_ff, idx_in;
   ntpt_pkg::entry_type  best_ff, best_in;
   logic [31:0]          best_age_ff, best_age_in;
   logic                 pend_valid_ff, pend_valid_in;
   ntpt_pkg::entry_type  pend_ff, pend_in;
   logic [31:0]          counter_ff, counter_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ntpt_pkg::rsp_type    rsp_ff, rsp_in;

   ntpt_pkg::cell_ctl_type ctl [TABLE_DEPTH];
   logic                   cell_used [TABLE_DEPTH];
   ntpt_pkg::entry_type    cell_data [TABLE_DEPTH];

   logic                clear_all;
   logic                do_load;
   logic                do_release;
   logic                head_used;
   ntpt_pkg::entry_type head;
   logic [31:0]         head_age;
   logic                head_hit;

   // build a result; entry fields are zero without an entry
   function automatic ntpt_pkg::rsp_type make_rsp(input logic [1:0] status,
                                                  input logic ev,
                                                  input ntpt_pkg::entry_type e,
                                                  input logic last);
      ntpt_pkg::rsp_type r;
      r.status      = status;
      r.entry_valid = ev;
      r.tag         = ev ? e.tag : 16'd0;
      r.start_time  = ev ? e.start_time : 31'd0;
      r.channel     = ev ? e.channel : 4'd0;
      r.note        = ev ? e.note : 8'd0;
      r.last        = last;
      return r;
   endfunction

   // ring of slot cells, cell 0 is the head seen by the compare unit
   generate
      for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         localparam int NEXT = (i + 1) % TABLE_DEPTH;
         always_comb begin
            ctl[i].shift        = (state_ff == ST_SCAN);
            ctl[i].clear_all    = clear_all;
            ctl[i].load         = do_load && (idx_ff == IW'(i));
            ctl[i].release_slot = do_release && (idx_ff == IW'(i));
         end
         ntpt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl[i]),
            .wr_data    (req_ff),
            .shift_used (cell_used[NEXT]),
            .shift_data (cell_data[NEXT]),
            .used_out   (cell_used[i]),
            .data_out   (cell_data[i])
         );
      end
   endgenerate

   assign head_used = cell_used[0];
   assign head      = cell_data[0];
   assign head_age  = counter_ff - head.order;
   assign head_hit  = head_used && (head.note == req_ff.note)
                      && (head.channel == req_ff.channel);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      req_in        = req_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_age_in   = best_age_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      counter_in    = counter_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      clear_all     = 1'b0;
      do_load       = 1'b0;
      do_release    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in              = req_operation;
               req_in.channel     = req_channel;
               req_in.note        = req_note;
               req_in.start_time  = req_start_time;
               req_in.tag         = req_tag;
               req_in.order       = counter_ff;
               found_in           = 1'b0;
               pend_valid_in      = 1'b0;
               step_in            = '0;
               if (req_operation == ntpt_pkg::OP_CLEAR) begin
                  clear_all    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(ntpt_pkg::STATUS_DONE, 1'b0, req_in, 1'b1);
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            case (op_ff)
               ntpt_pkg::OP_INSERT: begin
                  if (!found_ff && !head_used) begin
                     found_in = 1'b1;
                     idx_in   = step_ff;
                  end
               end
               ntpt_pkg::OP_MATCH: begin
                  if (head_hit && (!found_ff || head.start_time < best_ff.start_time
                      || (head.start_time == best_ff.start_time
                          && head_age < best_age_ff))) begin
                     found_in    = 1'b1;
                     idx_in      = step_ff;
                     best_in     = head;
                     best_age_in = head_age;
                  end
               end
               ntpt_pkg::OP_DUMP: begin
                  // hold one entry back so the final one can carry last
                  if (head_used) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(ntpt_pkg::STATUS_DUMP, 1'b1, pend_ff, 1'b0);
                     end
                     pend_valid_in = 1'b1;
                     pend_in       = head;
                  end
               end
               default: begin
               end
            endcase
            if (step_ff == IW'(TABLE_DEPTH - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               ntpt_pkg::OP_INSERT: begin
                  if (found_ff) begin
                     do_load    = 1'b1;
                     counter_in = counter_ff + 32'd1;
                     rsp_in = make_rsp(ntpt_pkg::STATUS_DONE, 1'b0, req_ff, 1'b1);
                  end else begin
                     rsp_in = make_rsp(ntpt_pkg::STATUS_FULL, 1'b0, req_ff, 1'b1);
                  end
               end
               ntpt_pkg::OP_MATCH: begin
                  if (found_ff) begin
                     do_release = 1'b1;
                     rsp_in = make_rsp(ntpt_pkg::STATUS_DONE, 1'b1, best_ff, 1'b1);
                  end else begin
                     rsp_in = make_rsp(ntpt_pkg::STATUS_NO_MATCH, 1'b0, best_ff, 1'b1);
                  end
               end
               default: begin
                  if (pend_valid_ff) begin
                     rsp_in = make_rsp(ntpt_pkg::STATUS_DUMP, 1'b1, pend_ff, 1'b1);
                  end else begin
                     rsp_in = make_rsp(ntpt_pkg::STATUS_DONE, 1'b0, pend_ff, 1'b1);
                  end
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         counter_ff    <= 32'd0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         counter_ff    <= counter_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         step_ff       <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_entry_valid = rsp_ff.entry_valid;
   assign rsp_tag_out     = rsp_ff.tag;
   assign rsp_time_out    = rsp_ff.start_time;
   assign rsp_channel_out = rsp_ff.channel;
   assign rsp_note_out    = rsp_ff.note;
   assign rsp_last        = rsp_ff.last;

   // a scanning command always begins its rotation at slot zero
   `NTPT_ASSERT_NXT(a_scan_begins, clock, reset, start && !busy && req_operation != ntpt_pkg::OP_CLEAR, state_ff == ST_SCAN && step_ff == '0)
   // a final result only appears once the sequencer is back in idle
   `NTPT_ASSERT_IMP(a_last_in_idle, clock, reset, rsp_valid_ff && rsp_ff.last, state_ff == ST_IDLE)
   // results without an entry carry zero entry fields
   `NTPT_ASSERT_IMP(a_empty_fields, clock, reset, rsp_valid && !rsp_entry_valid, rsp_tag_out == 16'd0 && rsp_time_out == 31'd0 && rsp_channel_out == 4'd0 && rsp_note_out == 8'd0)
   // the slot ring is never written while it is rotating
   `NTPT_ASSERT_IMP(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN, !do_load && !do_release && !clear_all)

endmodule
